### rtl/sdoled_pkg.sv
// Package: sizes, segment codes, glyph tables and sequencer states of the octal display unit.
`timescale 1ns / 1ps

package sdoled_pkg;

  localparam int GROUP_LEN   = 4;
  localparam int DIGIT_COUNT = 4;

  localparam int GRP_IDX_W = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 1;
  localparam int GRP_CNT_W = $clog2(GROUP_LEN + 1);
  localparam int POS_W     = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  localparam logic [15:0] MAX_SHOWN  = 16'o7777;
  localparam int          RAW_LIMIT  = (1 << (3 * DIGIT_COUNT)) - 1;
  localparam logic [15:0] SHOW_LIMIT = (RAW_LIMIT < 4095) ? 16'(RAW_LIMIT) : MAX_SHOWN;

  localparam logic [7:0] SG_A = 8'h02;
  localparam logic [7:0] SG_B = 8'h04;
  localparam logic [7:0] SG_C = 8'h40;
  localparam logic [7:0] SG_D = 8'h10;
  localparam logic [7:0] SG_E = 8'h08;
  localparam logic [7:0] SG_F = 8'h01;
  localparam logic [7:0] SG_G = 8'h20;

  localparam logic [7:0] SEL_NONE = 8'hff;
  localparam logic [7:0] SEG_NONE = 8'h00;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_BLANK  = 4'b0010,
    ST_DIGIT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  function automatic logic [7:0] oct_glyph(input logic [2:0] d);
    logic [7:0] g;
    unique case (d)
      3'd0: g = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F;
      3'd1: g = SG_B | SG_C;
      3'd2: g = SG_A | SG_B | SG_D | SG_E | SG_G;
      3'd3: g = SG_A | SG_B | SG_C | SG_D | SG_G;
      3'd4: g = SG_B | SG_C | SG_F | SG_G;
      3'd5: g = SG_A | SG_C | SG_D | SG_F | SG_G;
      3'd6: g = SG_A | SG_C | SG_D | SG_E | SG_F | SG_G;
      3'd7: g = SG_A | SG_B | SG_C;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] err_glyph(input logic [2:0] p);
    logic [7:0] g;
    unique case (p)
      3'd0:    g = SG_A | SG_D | SG_E | SG_F | SG_G;
      3'd1:    g = SG_E | SG_G;
      3'd2:    g = SG_C | SG_D | SG_E | SG_G;
      3'd3:    g = SG_E | SG_G;
      default: g = SEG_NONE;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] select_pat(input logic [2:0] p);
    logic [7:0] s;
    unique case (p)
      3'd0:    s = 8'hdf;
      3'd1:    s = 8'hef;
      3'd2:    s = 8'h7f;
      3'd3:    s = 8'hbf;
      3'd4:    s = 8'hfe;
      default: s = SEL_NONE;
    endcase
    return s;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

### rtl/serial_decimal_to_octal_led_display_unit.sv
// Top level: decimal text to octal seven-segment display with scan output.
`timescale 1ns / 1ps

// Each input word is either a received character (command 0) or a scan tick (command 1),
// and every word yields exactly one result word. A tick, or a character that does not
// complete a group, is answered in the next cycle. The character that completes a group
// starts a parse of the group, one character per cycle through a single shared
// multiply-by-ten accumulator, followed by a finish state that forms the value and glyphs.
// The block is busy from taking that character until the finish state ends, and the
// finish state waits while the previous result still sits untaken in the output register.
// A result waiting in the output register holds off the next input word until it is taken;
// a word can be taken in the same cycle.
module serial_decimal_to_octal_led_display_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_digit_select,
  output logic [7:0]  out_segments,
  output logic [11:0] out_shown_value,
  output logic        out_overflow
);

  sdoled_pkg::state_t state_r, state_nxt;

  logic [sdoled_pkg::GRP_IDX_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [sdoled_pkg::GRP_CNT_W-1:0] k_r, k_nxt;
  logic [15:0]                      acc_r, acc_nxt;
  logic                             neg_r, neg_nxt;
  logic [7:0]                       buf_r [sdoled_pkg::GROUP_LEN];
  logic [7:0]                       buf_nxt [sdoled_pkg::GROUP_LEN];
  logic [7:0]                       pat_r [sdoled_pkg::DIGIT_COUNT];
  logic [7:0]                       pat_nxt [sdoled_pkg::DIGIT_COUNT];
  logic [sdoled_pkg::POS_W-1:0]     scan_r, scan_nxt;
  logic [11:0]                      value_r, value_nxt;
  logic                             err_r, err_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  sel_r, sel_nxt;
  logic [7:0]  seg_r, seg_nxt;
  logic [11:0] shown_r, shown_nxt;
  logic        ovf_r, ovf_nxt;

  logic        out_free;
  logic        in_fire;
  logic [7:0]  cur;
  logic [15:0] dig;
  logic [15:0] acc_x10;
  logic [15:0] sum;
  logic        over;
  logic        last_k;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == sdoled_pkg::ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign cur     = buf_r[k_r[sdoled_pkg::GRP_IDX_W-1:0]];
  assign dig     = {12'd0, 4'(cur - sdoled_pkg::CH_ZERO)};
  assign acc_x10 = {acc_r[12:0], 3'b000} + {acc_r[14:0], 1'b0};
  assign sum     = (neg_r ? (16'd0 - acc_r) : acc_r) + 16'd1;
  assign over    = sum > sdoled_pkg::SHOW_LIMIT;
  assign last_k  = (k_r == sdoled_pkg::GRP_CNT_W'(sdoled_pkg::GROUP_LEN - 1));

  always_comb begin
    state_nxt     = state_r;
    byte_cnt_nxt  = byte_cnt_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    buf_nxt       = buf_r;
    pat_nxt       = pat_r;
    scan_nxt      = scan_r;
    value_nxt     = value_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sel_nxt       = sel_r;
    seg_nxt       = seg_r;
    shown_nxt     = shown_r;
    ovf_nxt       = ovf_r;
    unique case (state_r)
      sdoled_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          shown_nxt     = value_r;
          ovf_nxt       = err_r;
          if (in_command) begin
            sel_nxt = sdoled_pkg::select_pat(3'(scan_r));
            seg_nxt = pat_r[scan_r];
            if (scan_r == sdoled_pkg::POS_W'(sdoled_pkg::DIGIT_COUNT - 1)) begin
              scan_nxt = '0;
            end else begin
              scan_nxt = scan_r + 1'b1;
            end
          end else begin
            sel_nxt              = sdoled_pkg::SEL_NONE;
            seg_nxt              = sdoled_pkg::SEG_NONE;
            buf_nxt[byte_cnt_r]  = in_rx_byte;
            if (byte_cnt_r == sdoled_pkg::GRP_IDX_W'(sdoled_pkg::GROUP_LEN - 1)) begin
              byte_cnt_nxt  = '0;
              k_nxt         = '0;
              acc_nxt       = '0;
              neg_nxt       = 1'b0;
              out_valid_nxt = out_valid_r && !out_ready;
              sel_nxt       = sel_r;
              seg_nxt       = seg_r;
              shown_nxt     = shown_r;
              ovf_nxt       = ovf_r;
              state_nxt     = sdoled_pkg::ST_BLANK;
            end else begin
              byte_cnt_nxt = byte_cnt_r + 1'b1;
            end
          end
        end
      end
      sdoled_pkg::ST_BLANK: begin
        k_nxt = k_r + 1'b1;
        if (sdoled_pkg::is_blank(cur)) begin
          if (last_k) state_nxt = sdoled_pkg::ST_FINISH;
        end else if (cur == sdoled_pkg::CH_PLUS || cur == sdoled_pkg::CH_MINUS) begin
          neg_nxt   = (cur == sdoled_pkg::CH_MINUS);
          state_nxt = last_k ? sdoled_pkg::ST_FINISH : sdoled_pkg::ST_DIGIT;
        end else if (sdoled_pkg::is_digit(cur)) begin
          acc_nxt   = dig;
          state_nxt = last_k ? sdoled_pkg::ST_FINISH : sdoled_pkg::ST_DIGIT;
        end else begin
          state_nxt = sdoled_pkg::ST_FINISH;
        end
      end
      sdoled_pkg::ST_DIGIT: begin
        k_nxt = k_r + 1'b1;
        if (sdoled_pkg::is_digit(cur)) begin
          acc_nxt = acc_x10 + dig;
          if (last_k) state_nxt = sdoled_pkg::ST_FINISH;
        end else begin
          state_nxt = sdoled_pkg::ST_FINISH;
        end
      end
      sdoled_pkg::ST_FINISH: begin
        if (out_free) begin
          err_nxt   = over;
          value_nxt = over ? 12'd0 : sum[11:0];
          for (int p = 0; p < sdoled_pkg::DIGIT_COUNT; p++) begin
            pat_nxt[p] = over ? sdoled_pkg::err_glyph(3'(p))
                              : sdoled_pkg::oct_glyph(
                                  3'(sum >> (3 * (sdoled_pkg::DIGIT_COUNT - 1 - p))));
          end
          out_valid_nxt = 1'b1;
          sel_nxt       = sdoled_pkg::SEL_NONE;
          seg_nxt       = sdoled_pkg::SEG_NONE;
          shown_nxt     = over ? 12'd0 : sum[11:0];
          ovf_nxt       = over;
          state_nxt     = sdoled_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sdoled_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdoled_pkg::ST_IDLE;
      byte_cnt_r  <= '0;
      scan_r      <= '0;
      value_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < sdoled_pkg::DIGIT_COUNT; p++) begin
        pat_r[p] <= sdoled_pkg::oct_glyph(3'd0);
      end
    end else begin
      state_r     <= state_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      scan_r      <= scan_nxt;
      value_r     <= value_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      pat_r       <= pat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    acc_r   <= acc_nxt;
    neg_r   <= neg_nxt;
    buf_r   <= buf_nxt;
    sel_r   <= sel_nxt;
    seg_r   <= seg_nxt;
    shown_r <= shown_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_digit_select = sel_r;
  assign out_segments     = seg_r;
  assign out_shown_value  = shown_r;
  assign out_overflow     = ovf_r;

endmodule
